// File: hdl/ilir_pkg.sv
package ilir_pkg;

  localparam int FUNC_W   = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // update applied by every cell in the same cycle
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_WRITE  = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;
  localparam logic [1:0] CELL_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       rd_shift;
  } cell_ctl_t;

endpackage

// File: hdl/ilir_if.sv
interface ilir_in_if;
  import ilir_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface ilir_out_if;
  import ilir_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink (input valid, input read_value, input status, input count, output ready);
endinterface

// File: hdl/ilir_cell.sv
module ilir_cell
  import ilir_pkg::*;
#(
  parameter int PW  = 7,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [PW-1:0]            pos,
  input  logic [PW-1:0]            rd_pos,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic signed [DATA_W-1:0] left_ent,
  input  logic signed [DATA_W-1:0] right_ent,
  input  logic signed [DATA_W-1:0] rd_in,
  output logic signed [DATA_W-1:0] ent,
  output logic signed [DATA_W-1:0] rd_out
);

  localparam logic [PW-1:0] IDX_V = PW'(IDX);

  logic signed [DATA_W-1:0] ent_r, ent_nxt;
  logic signed [DATA_W-1:0] rd_r, rd_nxt;
  logic                     hit;
  logic                     above;

  assign hit   = (pos == IDX_V);
  assign above = (pos < IDX_V);

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.op)
      CELL_WRITE: begin
        if (hit) ent_nxt = wdata;
      end
      CELL_INSERT: begin
        if (hit) ent_nxt = wdata;
        else if (above) ent_nxt = left_ent;
      end
      CELL_REMOVE: begin
        if (hit || above) ent_nxt = right_ent;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  // read data walks down toward cell zero one cell per cycle while rd_shift is set
  always_comb begin
    rd_nxt = rd_r;
    if (ctl.rd_shift) rd_nxt = (rd_pos == IDX_V) ? ent_r : rd_in;
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    rd_r  <= rd_nxt;
  end

  assign ent    = ent_r;
  assign rd_out = rd_r;

endmodule

// File: hdl/indexed_list_insert_remove.sv
// Channel  Role    Payload
// in_ch    sink    func, position, value
// out_ch   source  read_value, status, count
//
// Write, insert, append, remove and every failed request put their result straight
// into the output register; the next request is taken once it drains.
// A successful read blocks new requests while the entry walks down the cell chain
// one cell per cycle to cell zero.
// rst_n (synchronous, active low) clears the count, the state and the output valid.
// A stalled result holds the output register and blocks new requests.
module indexed_list_insert_remove
  import ilir_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic       clk,
  input logic       rst_n,
  ilir_in_if.sink   in_ch,
  ilir_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                     state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         wait_r, wait_nxt;
  logic [PW-1:0]            rd_pos_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_rd_r;
  logic [STATUS_W-1:0]      out_st_r;
  logic [COUNT_W-1:0]       out_cnt_r;

  logic                     accept;
  logic                     go_read;
  logic [STATUS_W-1:0]      st;
  logic [1:0]               op;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [PW-1:0]            eff_pos;
  cell_ctl_t                ctl;

  logic signed [DATA_W-1:0] ent   [CAPACITY];
  logic signed [DATA_W-1:0] rd_ch [CAPACITY+1];

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_ext = PW'(in_ch.position);
  assign cnt_ext = PW'(count_r);

  always_comb begin
    st        = ST_OK;
    op        = CELL_HOLD;
    go_read   = 1'b0;
    eff_pos   = pos_ext;
    count_nxt = count_r;
    unique case (in_ch.func)
      FUNC_READ: begin
        if (pos_ext < cnt_ext) go_read = 1'b1;
        else st = ST_RANGE;
      end
      FUNC_WRITE: begin
        if (pos_ext < cnt_ext) op = CELL_WRITE;
        else st = ST_RANGE;
      end
      FUNC_INSERT: begin
        if (pos_ext > cnt_ext) st = ST_RANGE;
        else if (count_r == CNT_W'(CAPACITY)) st = ST_FULL;
        else begin
          op        = CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      FUNC_APPEND: begin
        eff_pos = cnt_ext;
        if (count_r == CNT_W'(CAPACITY)) st = ST_FULL;
        else begin
          op        = CELL_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (pos_ext < cnt_ext) begin
          op        = CELL_REMOVE;
          count_nxt = count_r - 1'b1;
        end else st = ST_RANGE;
      end
      default: st = ST_RANGE;
    endcase
  end

  assign ctl.op       = accept ? op : CELL_HOLD;
  assign ctl.rd_shift = (state_r == S_READ);

  assign rd_ch[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_ent;
    logic signed [DATA_W-1:0] right_ent;
    if (i == 0) begin : g_lo
      assign left_ent = ent[i];
    end else begin : g_lo
      assign left_ent = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_ent = ent[i];
    end else begin : g_hi
      assign right_ent = ent[i+1];
    end
    ilir_cell #(.PW(PW), .IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (eff_pos),
      .rd_pos    (rd_pos_r),
      .wdata     (in_ch.value),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .rd_in     (rd_ch[i+1]),
      .ent       (ent[i]),
      .rd_out    (rd_ch[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && go_read) begin
          state_nxt = S_READ;
          wait_nxt  = CNT_W'(CAPACITY);
        end
      end
      S_READ: begin
        if (wait_r == '0) state_nxt = S_IDLE;
        else wait_nxt = wait_r - 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      if (accept) count_r <= count_nxt;
      if (accept && !go_read) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_READ && wait_r == '0) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && go_read) rd_pos_r <= pos_ext;
    if (accept && !go_read) begin
      out_rd_r  <= '0;
      out_st_r  <= st;
      out_cnt_r <= COUNT_W'(count_nxt);
    end else if (state_r == S_READ && wait_r == '0) begin
      out_rd_r  <= rd_ch[0];
      out_st_r  <= ST_OK;
      out_cnt_r <= COUNT_W'(count_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.count      = out_cnt_r;

endmodule

// File: tb/indexed_list_insert_remove_tb.sv
`timescale 1ns / 100ps

module indexed_list_insert_remove_tb;
  import ilir_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } list_reply_t;

  logic clk;
  logic rst_n;

  ilir_in_if  in_ch ();
  ilir_out_if out_ch ();

  indexed_list_insert_remove #(
    .CAPACITY(LIST_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic signed [DATA_W-1:0] shadow_entries [LIST_DEPTH];
  int unsigned              shadow_count;
  list_reply_t              expected_replies [$];

  int  source_gap_pct;
  int  sink_stall_pct;
  int  mismatch_total;
  int  cycle_count;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic logic [STATUS_W-1:0] shadow_insert(input int unsigned slot,
                                                        input logic signed [DATA_W-1:0] v);
    if (slot > shadow_count) return ST_RANGE;
    if (shadow_count >= LIST_DEPTH) return ST_FULL;
    for (int i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[slot] = v;
    shadow_count++;
    return ST_OK;
  endfunction

  function automatic list_reply_t apply_list_op(input logic [FUNC_W-1:0] f,
                                                input logic [POS_W-1:0] p,
                                                input logic signed [DATA_W-1:0] v);
    list_reply_t r;
    r.read_value = '0;
    r.status     = ST_OK;
    case (f)
      FUNC_READ: begin
        if (p < shadow_count) r.read_value = shadow_entries[p];
        else r.status = ST_RANGE;
      end
      FUNC_WRITE: begin
        if (p < shadow_count) shadow_entries[p] = v;
        else r.status = ST_RANGE;
      end
      FUNC_INSERT: r.status = shadow_insert(p, v);
      FUNC_APPEND: r.status = shadow_insert(shadow_count, v);
      FUNC_REMOVE: begin
        if (p < shadow_count) begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                              input logic signed [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < source_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.position <= p;
    in_ch.value    <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_replies.push_back(apply_list_op(f, p, v));
  endtask

  always @(posedge clk) begin
    list_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("reply with no request pending: read_value %0d status %0d count %0d",
               out_ch.read_value, out_ch.status, out_ch.count);
        mismatch_total++;
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_ch.read_value);
          mismatch_total++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatch_total++;
        end
        if (out_ch.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_ch.count);
          mismatch_total++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_request(FUNC_READ, 7'd0, 32'sd5);
    send_request(FUNC_WRITE, 7'd0, 32'sd5);
    send_request(FUNC_REMOVE, 7'd0, 32'sd0);
    send_request(FUNC_INSERT, 7'd1, 32'sd9);
    send_request(FUNC_READ, 7'd127, 32'sd0);
    send_request(3'd5, 7'd0, 32'sd1);
    send_request(3'd6, 7'd0, 32'sd1);
    send_request(3'd7, 7'd127, -32'sd1);
  endtask

  task automatic test_edit_ops();
    send_request(FUNC_INSERT, 7'd0, 32'sh7fffffff);
    // position is ignored on append
    send_request(FUNC_APPEND, 7'd127, 32'sh80000000);
    send_request(FUNC_INSERT, 7'd1, 32'sd0);
    send_request(FUNC_INSERT, 7'd3, -32'sd1);
    send_request(FUNC_INSERT, 7'd5, 32'sd3);
    send_request(FUNC_READ, 7'd0, 32'sd0);
    send_request(FUNC_READ, 7'd1, 32'sd0);
    send_request(FUNC_READ, 7'd3, 32'sd0);
    send_request(FUNC_READ, 7'd4, 32'sd0);
    send_request(FUNC_WRITE, 7'd2, 32'sh5a5a5a5a);
    send_request(FUNC_WRITE, 7'd4, 32'sd1);
    send_request(FUNC_READ, 7'd2, 32'sd0);
    send_request(FUNC_REMOVE, 7'd0, 32'sd0);
    send_request(FUNC_REMOVE, 7'd2, 32'sd0);
    send_request(FUNC_REMOVE, 7'd2, 32'sd0);
    send_request(FUNC_READ, 7'd1, 32'sd0);
    send_request(FUNC_REMOVE, 7'd64, 32'sd0);
    send_request(FUNC_REMOVE, 7'd0, 32'sd0);
    send_request(FUNC_REMOVE, 7'd0, 32'sd0);
  endtask

  task automatic test_full_list();
    while (shadow_count < LIST_DEPTH) begin
      send_request(FUNC_APPEND, POS_W'($urandom_range(0, 127)), DATA_W'($urandom));
    end
    send_request(FUNC_INSERT, 7'd0, 32'sd1);
    send_request(FUNC_APPEND, 7'd0, 32'sd1);
    send_request(FUNC_INSERT, 7'd64, 32'sd1);
    // range check wins over the full check
    send_request(FUNC_INSERT, 7'd65, 32'sd1);
    send_request(FUNC_WRITE, 7'd63, 32'sh80000000);
    send_request(FUNC_READ, 7'd63, 32'sd0);
    send_request(FUNC_READ, 7'd64, 32'sd0);
    send_request(FUNC_READ, 7'd0, 32'sd0);
    send_request(FUNC_REMOVE, 7'd63, 32'sd0);
    send_request(FUNC_REMOVE, 7'd0, 32'sd0);
    send_request(FUNC_INSERT, 7'd62, 32'sh7fffffff);
    send_request(FUNC_READ, 7'd62, 32'sd0);
  endtask

  task automatic test_random_ops(input int n, input int grow_pct);
    int                       r;
    logic [FUNC_W-1:0]        f;
    logic [POS_W-1:0]         p;
    logic signed [DATA_W-1:0] v;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) f = FUNC_W'($urandom_range(5, 7));
      else if (r < 22) f = FUNC_READ;
      else if (r < 36) f = FUNC_WRITE;
      else if ($urandom_range(0, 99) < grow_pct) begin
        f = $urandom_range(0, 1) ? FUNC_INSERT : FUNC_APPEND;
      end
      else f = FUNC_REMOVE;
      if ($urandom_range(0, 99) < 12) p = POS_W'($urandom_range(0, 127));
      else p = POS_W'($urandom_range(0, shadow_count));
      case ($urandom_range(0, 15))
        0: v = 32'sh7fffffff;
        1: v = 32'sh80000000;
        2: v = '0;
        default: v = DATA_W'($urandom);
      endcase
      send_request(f, p, v);
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_READ;
    in_ch.position = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    shadow_count   = 0;
    mismatch_total = 0;
    cycle_count    = 0;
    source_gap_pct = 31;
    sink_stall_pct = 47;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edit_ops();
    test_full_list();
    test_random_ops(170, 70);
    source_gap_pct = 47;
    sink_stall_pct = 31;
    test_random_ops(170, 30);
    source_gap_pct = 0;
    sink_stall_pct = 0;
    test_random_ops(170, 55);

    in_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    // hold for a full read walk in case a stray reply follows
    repeat (LIST_DEPTH + 8) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
